// ===== rtl/yc48_pkg.sv =====
// ----------------------------------------------------------------------------
// yc48_pkg: shared types and arithmetic for the 16-bit 4:2:2 to YC48 block
// Fixed-point scaling of luma and chroma, the floored chroma average and the
// layout of one result pair.
// ----------------------------------------------------------------------------
package yc48_pkg;

    localparam logic signed [16:0] LUMA_OFFSET = 17'sd4096;
    localparam logic signed [13:0] LUMA_GAIN   = 14'sd4789;
    localparam logic signed [13:0] CHROMA_GAIN = 14'sd4683;

    // Depth of the result queue, and its pointer width
    localparam int unsigned      RES_DEPTH = 3;
    localparam int unsigned      PTR_W     = 2;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RES_DEPTH - 1);

    typedef logic signed [13:0] luma_t;
    typedef logic signed [12:0] chroma_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [PTR_W:0]     count_t;

    typedef struct packed {
        luma_t   even_y;
        chroma_t even_u;
        chroma_t even_v;
        luma_t   odd_y;
        chroma_t odd_u;
        chroma_t odd_v;
        logic    row_last;
        logic    run_last;
    } result_t;

    // (Y - 4096) * 4789, arithmetic shift right by 16
    function automatic luma_t scale_luma(input logic [15:0] y);
        logic signed [16:0] v;
        logic signed [30:0] p;
        v = $signed({1'b0, y}) - LUMA_OFFSET;
        p = 31'(v) * 31'(LUMA_GAIN);
        return p[29:16];
    endfunction

    // (C - 32768) * 4683, arithmetic shift right by 16
    function automatic chroma_t scale_chroma(input logic [15:0] c);
        logic signed [15:0] v;
        logic signed [28:0] p;
        v = $signed({~c[15], c[14:0]});
        p = 29'(v) * 29'(CHROMA_GAIN);
        return p[28:16];
    endfunction

    // Floored average of two scaled chroma samples
    function automatic chroma_t avg_floor(input chroma_t a, input chroma_t b);
        logic signed [13:0] s;
        s = 14'(a) + 14'(b);
        return s[13:1];
    endfunction

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/yuv422_16bit_to_yc48_upsample.sv =====
// ----------------------------------------------------------------------------
// yuv422_16bit_to_yc48_upsample: 16-bit 4:2:2 pairs to YC48 with chroma upsampling
// Scales luma and chroma to YC48 range and interpolates the odd pixel's chroma
// from the current and the next pair; the last pair of a row copies its chroma.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid/s_ready, s_luma_even/odd, s_chroma_u/v, | in
//          | s_row_end                                     |
//  result  | m_valid/m_ready, m_even_y/u/v, m_odd_y/u/v,     | out
//          | m_row_last, m_run_last                        |
//
//  One input transaction is taken per cycle while the queue has room for all of its
//  results; they reach the result port from the input register through a three-entry queue.
//  A transaction yields 0, 1 or 2 results; a pair that ends a row behind a
//  held pair pushes two at once, and the queue keeps the rate at one per cycle.
//  Reset (aresetn low, synchronous) empties the input register, the queue and
//  the held pair. A stall on m_ready fills the queue, then holds the input.
//
module yuv422_16bit_to_yc48_upsample
    import yc48_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_luma_even,
    input  logic [15:0]   s_luma_odd,
    input  logic [15:0]   s_chroma_u,
    input  logic [15:0]   s_chroma_v,
    input  logic          s_row_end,

    output logic          m_valid,
    input  logic          m_ready,
    output logic signed [13:0] m_even_y,
    output logic signed [12:0] m_even_u,
    output logic signed [12:0] m_even_v,
    output logic signed [13:0] m_odd_y,
    output logic signed [12:0] m_odd_u,
    output logic signed [12:0] m_odd_v,
    output logic          m_row_last,
    output logic          m_run_last
);

    // Input register: raw transaction waiting to be processed
    logic        in_vld_reg;
    logic [15:0] in_luma_even_reg;
    logic [15:0] in_luma_odd_reg;
    logic [15:0] in_chroma_u_reg;
    logic [15:0] in_chroma_v_reg;
    logic        in_row_end_reg;

    // Held pair, already scaled, waiting for the next pair's chroma
    logic    held_valid_reg;
    luma_t   held_luma_even_reg;
    luma_t   held_luma_odd_reg;
    chroma_t held_cb_reg;
    chroma_t held_cr_reg;

    // Result queue
    result_t res_mem [RES_DEPTH];
    ptr_t    wr_ptr_reg, wr_ptr_next;
    ptr_t    rd_ptr_reg, rd_ptr_next;
    count_t  cnt_reg, cnt_next;

    luma_t   new_y_even, new_y_odd;
    chroma_t new_cb, new_cr;
    result_t held_res, new_res;
    count_t  push_cnt;
    logic    in_fire;
    logic    out_fire;
    logic    s_fire;

    // Scale the registered pair
    assign new_y_even = scale_luma(in_luma_even_reg);
    assign new_y_odd  = scale_luma(in_luma_odd_reg);
    assign new_cb     = scale_chroma(in_chroma_u_reg);
    assign new_cr     = scale_chroma(in_chroma_v_reg);

    // Held pair goes out with its odd chroma averaged against the new pair
    always_comb begin
        held_res.even_y   = held_luma_even_reg;
        held_res.even_u   = held_cb_reg;
        held_res.even_v   = held_cr_reg;
        held_res.odd_y    = held_luma_odd_reg;
        held_res.odd_u    = avg_floor(held_cb_reg, new_cb);
        held_res.odd_v    = avg_floor(held_cr_reg, new_cr);
        held_res.row_last = 1'b0;
        held_res.run_last = ~in_row_end_reg;

        // End-of-row pair: odd pixel copies the even pixel's chroma
        new_res.even_y    = new_y_even;
        new_res.even_u    = new_cb;
        new_res.even_v    = new_cr;
        new_res.odd_y     = new_y_odd;
        new_res.odd_u     = new_cb;
        new_res.odd_v     = new_cr;
        new_res.row_last  = 1'b1;
        new_res.run_last  = 1'b1;
    end

    // Results this transaction pushes; advance only when they all fit
    assign push_cnt = count_t'(held_valid_reg) + count_t'(in_row_end_reg);
    assign in_fire  = in_vld_reg && ((cnt_reg + push_cnt) <= count_t'(RES_DEPTH));
    assign out_fire = m_valid && m_ready;
    assign s_ready  = ~in_vld_reg | in_fire;
    assign s_fire   = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_fire) begin
            in_luma_even_reg <= s_luma_even;
            in_luma_odd_reg  <= s_luma_odd;
            in_chroma_u_reg  <= s_chroma_u;
            in_chroma_v_reg  <= s_chroma_v;
            in_row_end_reg   <= s_row_end;
        end
    end

    // Hold the pair unless it ends a row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
        end else if (in_fire) begin
            held_valid_reg <= ~in_row_end_reg;
        end
        if (in_fire && !in_row_end_reg) begin
            held_luma_even_reg <= new_y_even;
            held_luma_odd_reg  <= new_y_odd;
            held_cb_reg        <= new_cb;
            held_cr_reg        <= new_cr;
        end
    end

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (in_fire) begin
            if (push_cnt == count_t'(2)) begin
                wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
            end else if (push_cnt == count_t'(1)) begin
                wr_ptr_next = ptr_inc(wr_ptr_reg);
            end
            cnt_next = cnt_next + push_cnt;
        end
        if (out_fire) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            cnt_next    = cnt_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write the held pair first, then the end-of-row pair behind it
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (held_valid_reg) begin
                res_mem[wr_ptr_reg] <= held_res;
                if (in_row_end_reg) begin
                    res_mem[ptr_inc(wr_ptr_reg)] <= new_res;
                end
            end else if (in_row_end_reg) begin
                res_mem[wr_ptr_reg] <= new_res;
            end
        end
    end

    // Result port reads straight from the queue head
    assign m_valid    = (cnt_reg != '0);
    assign m_even_y   = res_mem[rd_ptr_reg].even_y;
    assign m_even_u   = res_mem[rd_ptr_reg].even_u;
    assign m_even_v   = res_mem[rd_ptr_reg].even_v;
    assign m_odd_y    = res_mem[rd_ptr_reg].odd_y;
    assign m_odd_u    = res_mem[rd_ptr_reg].odd_u;
    assign m_odd_v    = res_mem[rd_ptr_reg].odd_v;
    assign m_row_last = res_mem[rd_ptr_reg].row_last;
    assign m_run_last = res_mem[rd_ptr_reg].run_last;

    // The queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= count_t'(RES_DEPTH))
        else $error("result queue overfilled");

    // A row-ending pair is always the last result of its transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_last) |-> m_run_last)
        else $error("row end result not marked last of transaction");

    // Nothing stays held after a row ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_row_end_reg) |=> !held_valid_reg)
        else $error("pair held across row end");

    // A processed pair never leaves the queue count unchanged unless it is only held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !out_fire && (held_valid_reg || in_row_end_reg)) |=>
            (cnt_reg != $past(cnt_reg)))
        else $error("results lost from queue");

endmodule
